>>> hdl/rpcf_pkg.sv
// Shared types, register codes and field helpers for the ring photon candidate filter.
// Used by every module of the block and by its checker; depends on nothing.
package rpcf_pkg;

  localparam int unsigned NUM_HYPOTHESES = 6;
  localparam int unsigned NUM_RADIATORS  = 3;
  localparam int unsigned COUNT_WIDTH    = 32;

  localparam int unsigned REG_W   = 48;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned RAD_W   = 2;
  localparam int unsigned SEP2_W  = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned HCNT_W  = 3;

  typedef logic [REG_W-1:0]   reg48_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [TOTAL_W-1:0] total_t;

  typedef enum logic [2:0] {
    CFG_MIN_SEP_WINDOW     = 3'd0,
    CFG_MAX_SEP_WINDOW     = 3'd1,
    CFG_SEP_TOLERANCE      = 3'd2,
    CFG_ANGLE_TO_SEP_SCALE = 3'd3,
    CFG_MIN_ABS_X          = 3'd4,
    CFG_MIN_ABS_Y          = 3'd5,
    CFG_HYPOTHESIS_COUNT   = 3'd6
  } cfg_idx_e;

  localparam reg48_t RST_MIN_SEP_WINDOW     = 48'd1760;
  localparam reg48_t RST_MAX_SEP_WINDOW     = 48'd11338803845216;
  localparam reg48_t RST_SEP_TOLERANCE      = 48'd2748794798480;
  localparam reg48_t RST_ANGLE_TO_SEP_SCALE = 48'd74445046224452;
  localparam reg48_t RST_MIN_ABS_X          = 48'd281410551218160;
  localparam reg48_t RST_MIN_ABS_Y          = 48'd281410551218160;
  localparam logic [HCNT_W-1:0] RST_HYPOTHESIS_COUNT = 3'd5;

  typedef struct packed {
    logic [RAD_W-1:0]    radiator;
    logic                segment_detector;
    logic                pixel_detector;
    logic signed [15:0]  local_x;
    logic signed [15:0]  local_y;
    logic [SEP2_W-1:0]   sep_squared;
    logic [15:0]         theta_hyp0;
    logic [15:0]         theta_hyp1;
    logic [15:0]         theta_hyp2;
    logic [15:0]         theta_hyp3;
    logic [15:0]         theta_hyp4;
    logic [15:0]         theta_hyp5;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    total_t accepted_total;
    total_t rejected_total;
  } out_item_t;

  // Per-radiator 16-bit field of a packed register; a radiator with no field reads zero.
  function automatic field_t field_of(reg48_t value, logic [RAD_W-1:0] rad);
    field_t f;
    case (rad)
      2'd0:    f = value[15:0];
      2'd1:    f = value[31:16];
      2'd2:    f = value[47:32];
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [15:0] theta_of(in_item_t item, int unsigned h);
    logic [15:0] t;
    case (h)
      0:       t = item.theta_hyp0;
      1:       t = item.theta_hyp1;
      2:       t = item.theta_hyp2;
      3:       t = item.theta_hyp3;
      4:       t = item.theta_hyp4;
      5:       t = item.theta_hyp5;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Magnitude of a signed 16-bit position, 17 bits so that -32768 stays exact.
  function automatic logic [16:0] abs16(logic signed [15:0] v);
    logic [16:0] sx;
    sx = {v[15], v};
    return v[15] ? 17'(17'd0 - sx) : sx;
  endfunction

endpackage

>>> hdl/rpcf_lane.sv
// One hypothesis lane: expected separation, tolerance band squared, band test.
// Depends on rpcf_pkg for field widths.
module rpcf_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [15:0]                    theta_i,
  input  rpcf_pkg::field_t               scale_i,
  input  rpcf_pkg::field_t               tol_i,
  input  logic [rpcf_pkg::SEP2_W-1:0]    sep_i,
  input  logic                           lane_on_i,
  output logic                           hit_o
);

  logic [31:0] prod_q;
  logic [17:0] expect_sep;
  logic [18:0] up;
  logic [17:0] dn;
  logic        below;
  logic [37:0] up2_q;
  logic [35:0] dn2_q;
  logic        below_q;

  // Expected separation in 1/16 mm is the product shifted down by 14.
  assign expect_sep = prod_q[31:14];
  assign below      = expect_sep < 18'(tol_i);
  assign up         = 19'(expect_sep) + 19'(tol_i);
  assign dn         = below ? '0 : 18'(expect_sep - 18'(tol_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 32'(theta_i) * 32'(scale_i);
      up2_q   <= 38'(up) * 38'(up);
      dn2_q   <= 36'(dn) * 36'(dn);
      below_q <= below;
    end
  end

  assign hit_o = lane_on_i && (below_q || (36'(sep_i) > dn2_q)) && (38'(sep_i) < up2_q);

endmodule

>>> hdl/rpcf_tally.sv
// Lane merge, per-radiator saturating counters and the output register.
// Depends on rpcf_pkg for the result type and widths.
module rpcf_tally #(
  parameter int unsigned NumRadiators = rpcf_pkg::NUM_RADIATORS,
  parameter int unsigned CountWidth   = rpcf_pkg::COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [rpcf_pkg::RAD_W-1:0]          rad_i,
  input  logic                                rad_ok_i,
  input  logic                                pre_ok_i,
  input  logic [rpcf_pkg::NUM_HYPOTHESES-1:0] hits_i,
  output logic                                out_valid_o,
  output rpcf_pkg::out_item_t                 out_data_o
);

  logic [CountWidth-1:0] acc_q [NumRadiators];
  logic [CountWidth-1:0] acc_d [NumRadiators];
  logic [CountWidth-1:0] rej_q [NumRadiators];
  logic [CountWidth-1:0] rej_d [NumRadiators];
  logic [CountWidth-1:0] sel_acc, sel_rej, new_acc, new_rej;
  logic                  ok;
  logic                  upd;
  logic                  out_valid_q, out_valid_d;
  rpcf_pkg::out_item_t   out_q, out_d;

  assign ok  = pre_ok_i && (|hits_i);
  assign upd = en_i && valid_i && rad_ok_i;

  always_comb begin
    sel_acc = '0;
    sel_rej = '0;
    for (int r = 0; r < NumRadiators; r++) begin
      if (rad_i == rpcf_pkg::RAD_W'(r)) begin
        sel_acc = acc_q[r];
        sel_rej = rej_q[r];
      end
    end
    // A full counter holds its maximum.
    new_acc = (ok && (sel_acc != '1)) ? CountWidth'(sel_acc + CountWidth'(1)) : sel_acc;
    new_rej = (!ok && (sel_rej != '1)) ? CountWidth'(sel_rej + CountWidth'(1)) : sel_rej;
  end

  always_comb begin
    for (int r = 0; r < NumRadiators; r++) begin
      acc_d[r] = acc_q[r];
      rej_d[r] = rej_q[r];
      if (upd && (rad_i == rpcf_pkg::RAD_W'(r))) begin
        acc_d[r] = new_acc;
        rej_d[r] = new_rej;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (en_i) begin
      out_valid_d = valid_i;
      if (rad_ok_i) begin
        out_d.accepted       = ok;
        out_d.accepted_total = rpcf_pkg::total_t'(new_acc);
        out_d.rejected_total = rpcf_pkg::total_t'(new_rej);
      end else begin
        out_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int r = 0; r < NumRadiators; r++) begin
        acc_q[r] <= '0;
        rej_q[r] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      for (int r = 0; r < NumRadiators; r++) begin
        acc_q[r] <= acc_d[r];
        rej_q[r] <= rej_d[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/ring_photon_candidate_filter.sv
// Top level of the ring photon candidate filter: configuration registers, the
// geometric cuts and the hypothesis lanes. Depends on rpcf_pkg, rpcf_lane, rpcf_tally.
//
// Usage: one track-segment/pixel pair enters as a beat on the input channel
// (in_valid_i, in_stall_o, in_data_i) and exactly one result beat leaves on the
// output channel (out_valid_o, out_stall_i, out_data_o), in the same order.
// The block is a three-stage pipeline: stage one forms theta*scale in every lane
// and the squared window bounds, stage two squares the tolerance band of each
// lane, stage three merges the lanes and updates the radiator's counters into
// the output register. One pair is taken per cycle unless the output is stalled.
// The lane multipliers set the stage split: one product per lane in stage one and
// the two band squares per lane in stage two.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle; it falls as soon as the result is taken.
// Reset clears the counters, all pipeline valid bits and the configuration
// registers to their defaults. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at the next edge and belong to idle periods only.
module ring_photon_candidate_filter #(
  parameter int unsigned NumRadiators = rpcf_pkg::NUM_RADIATORS,
  parameter int unsigned CountWidth   = rpcf_pkg::COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rpcf_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rpcf_pkg::out_item_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  rpcf_pkg::reg48_t      cfg_data_i
);

  localparam int unsigned NH = rpcf_pkg::NUM_HYPOTHESES;

  rpcf_pkg::reg48_t min_sep_q, max_sep_q, tol_q, scale_q, min_x_q, min_y_q;
  logic [rpcf_pkg::HCNT_W-1:0] hyp_cnt_q;

  logic adv;

  // Stage 0 combinational.
  rpcf_pkg::field_t lo0, hi0, tol0, scale0, minx0, miny0;
  logic             geo_ok0, rad_ok0;

  // Stage 1 registers.
  logic                          v1_q;
  logic [rpcf_pkg::RAD_W-1:0]    rad1_q;
  logic                          rad_ok1_q, geo_ok1_q;
  logic [rpcf_pkg::SEP2_W-1:0]   sep1_q;
  rpcf_pkg::field_t              tol1_q;
  logic [31:0]                   lo2_1_q, hi2_1_q;

  // Stage 2 registers.
  logic                          v2_q;
  logic [rpcf_pkg::RAD_W-1:0]    rad2_q;
  logic                          rad_ok2_q, pre_ok2_q;
  logic [rpcf_pkg::SEP2_W-1:0]   sep2_q;

  logic [NH-1:0] hits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sep_q <= rpcf_pkg::RST_MIN_SEP_WINDOW;
      max_sep_q <= rpcf_pkg::RST_MAX_SEP_WINDOW;
      tol_q     <= rpcf_pkg::RST_SEP_TOLERANCE;
      scale_q   <= rpcf_pkg::RST_ANGLE_TO_SEP_SCALE;
      min_x_q   <= rpcf_pkg::RST_MIN_ABS_X;
      min_y_q   <= rpcf_pkg::RST_MIN_ABS_Y;
      hyp_cnt_q <= rpcf_pkg::RST_HYPOTHESIS_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpcf_pkg::CFG_MIN_SEP_WINDOW:     min_sep_q <= cfg_data_i;
        rpcf_pkg::CFG_MAX_SEP_WINDOW:     max_sep_q <= cfg_data_i;
        rpcf_pkg::CFG_SEP_TOLERANCE:      tol_q     <= cfg_data_i;
        rpcf_pkg::CFG_ANGLE_TO_SEP_SCALE: scale_q   <= cfg_data_i;
        rpcf_pkg::CFG_MIN_ABS_X:          min_x_q   <= cfg_data_i;
        rpcf_pkg::CFG_MIN_ABS_Y:          min_y_q   <= cfg_data_i;
        rpcf_pkg::CFG_HYPOTHESIS_COUNT:   hyp_cnt_q <= cfg_data_i[rpcf_pkg::HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unless a finished result is held by the receiver.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    lo0     = rpcf_pkg::field_of(min_sep_q, in_data_i.radiator);
    hi0     = rpcf_pkg::field_of(max_sep_q, in_data_i.radiator);
    tol0    = rpcf_pkg::field_of(tol_q,     in_data_i.radiator);
    scale0  = rpcf_pkg::field_of(scale_q,   in_data_i.radiator);
    minx0   = rpcf_pkg::field_of(min_x_q,   in_data_i.radiator);
    miny0   = rpcf_pkg::field_of(min_y_q,   in_data_i.radiator);
    rad_ok0 = 3'(in_data_i.radiator) < 3'(NumRadiators);
    // Central cut: pass if the detector flags agree and either coordinate clears the signed minimum.
    geo_ok0 = (in_data_i.segment_detector == in_data_i.pixel_detector) &&
              (($signed({1'b0, rpcf_pkg::abs16(in_data_i.local_x)}) >
                $signed({{2{minx0[15]}}, minx0})) ||
               ($signed({1'b0, rpcf_pkg::abs16(in_data_i.local_y)}) >
                $signed({{2{miny0[15]}}, miny0})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad1_q    <= in_data_i.radiator;
      rad_ok1_q <= rad_ok0;
      geo_ok1_q <= geo_ok0;
      sep1_q    <= in_data_i.sep_squared;
      tol1_q    <= tol0;
      lo2_1_q   <= 32'(lo0) * 32'(lo0);
      hi2_1_q   <= 32'(hi0) * 32'(hi0);
      rad2_q    <= rad1_q;
      rad_ok2_q <= rad_ok1_q;
      pre_ok2_q <= geo_ok1_q && (sep1_q < hi2_1_q) && (sep1_q > lo2_1_q);
      sep2_q    <= sep1_q;
    end
  end

  for (genvar h = 0; h < NH; h++) begin : g_lane
    rpcf_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (adv),
      .theta_i   (rpcf_pkg::theta_of(in_data_i, h)),
      .scale_i   (scale0),
      .tol_i     (tol1_q),
      .sep_i     (sep2_q),
      .lane_on_i (rpcf_pkg::HCNT_W'(h) < hyp_cnt_q),
      .hit_o     (hits[h])
    );
  end

  rpcf_tally #(
    .NumRadiators (NumRadiators),
    .CountWidth   (CountWidth)
  ) u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (v2_q),
    .rad_i       (rad2_q),
    .rad_ok_i    (rad_ok2_q),
    .pre_ok_i    (pre_ok2_q),
    .hits_i      (hits),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/rpcf_checker.sv
// Port-level checker for the ring photon candidate filter and its bind.
// Depends on rpcf_pkg and the top level's port list.
module rpcf_checker #(
  parameter int unsigned CountWidth   = rpcf_pkg::COUNT_WIDTH
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input rpcf_pkg::out_item_t   out_data_o
);

  // The input side stalls only behind a result the receiver is holding back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // With the output free, the input side is never held.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output is free");

  // A held result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("held result beat changed");

  // An accepted pair has been counted, so its radiator's accept total is nonzero.
  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted && (CountWidth <= 32)) |->
      (out_data_o.accepted_total != '0))
    else $error("accepted beat with zero accept total");

endmodule

bind ring_photon_candidate_filter rpcf_checker #(
  .CountWidth   (CountWidth)
) u_rpcf_checker (.*);
